[design/volume_overlap_resampler_macros.svh]
// Assertion helpers shared by the resampler RTL
`ifndef VOLUME_OVERLAP_RESAMPLER_MACROS_SVH
`define VOLUME_OVERLAP_RESAMPLER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define VOR_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("volume_overlap_resampler: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define VOR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("volume_overlap_resampler: next-cycle check failed");

`endif

[design/vor_pkg.sv]
`default_nettype none

package vor_pkg;

    // Store geometry
    localparam int STORE_DEPTH = 32768;
    localparam int ADDR_W      = 15;
    localparam int DATA_W      = 32;
    localparam int SPC_W       = 24;

    // Grid defaults
    localparam int SRC_NX_DEF   = 32;
    localparam int SRC_NY_DEF   = 32;
    localparam int SRC_NZ_DEF   = 32;
    localparam int MAX_SPAN_DEF = 8;

    // Shared divider widths
    localparam int DIV_W = 64;
    localparam int DVS_W = 34;

    // Q0.16 fraction, one needs 17 bits
    localparam int                FRAC_W   = 17;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    // Register indexes
    localparam int         CFG_IDX_W     = 3;
    localparam logic [2:0] CFG_SRC_SPC_X = 3'd0;
    localparam logic [2:0] CFG_SRC_SPC_Y = 3'd1;
    localparam logic [2:0] CFG_SRC_SPC_Z = 3'd2;
    localparam logic [2:0] CFG_DST_SPC_X = 3'd3;
    localparam logic [2:0] CFG_DST_SPC_Y = 3'd4;
    localparam logic [2:0] CFG_DST_SPC_Z = 3'd5;
    localparam logic [2:0] CFG_FILL      = 3'd6;

    localparam logic [SPC_W-1:0] SPC_RESET = 24'd65536;

    // Request kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic [ADDR_W-1:0]        load_address;
        logic signed [DATA_W-1:0] load_value;
        logic signed [31:0]       corner_x;
        logic signed [31:0]       corner_y;
        logic signed [31:0]       corner_z;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] resampled_value;
        logic                     empty_flag;
        logic                     clipped_flag;
    } out_item_t;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

[design/vor_ram.sv]
`default_nettype none

module vor_ram #(
    parameter int WIDTH = vor_pkg::DATA_W,
    parameter int DEPTH = vor_pkg::STORE_DEPTH
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/vor_div.sv]
`default_nettype none

module vor_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire vor_pkg::div_req_t  req,
    output vor_pkg::div_rsp_t       rsp
);

    localparam int CNT_W = $clog2(vor_pkg::DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(vor_pkg::DIV_W - 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [vor_pkg::DVS_W-1:0]   rem_reg;
    logic [vor_pkg::DVS_W-1:0]   dvs_reg;
    logic [vor_pkg::DIV_W-1:0]   quo_reg;
    logic [vor_pkg::DVS_W:0]     trial;
    logic [vor_pkg::DVS_W:0]     diff;
    logic                        fits;

    // Restoring step: one quotient bit per cycle
    always_comb begin
        trial = {rem_reg, quo_reg[vor_pkg::DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[vor_pkg::DVS_W-1:0] : trial[vor_pkg::DVS_W-1:0];
            quo_reg <= {quo_reg[vor_pkg::DIV_W-2:0], fits};
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

[design/volume_overlap_resampler.sv]
// Load request: written to the voxel store when it is accepted.
// Query request: runs in the shared 64-step divider (four divides per axis and
// the final average, which is skipped when no weight was gathered), then walks
// the window one voxel per cycle through the single store read port, then drains.
// One query is in flight at a time; a finished result waits in the output register.
// Reset (aresetn, synchronous, active low) restores spacings to 1.0 mm and
// fill to 0; the voxel store is not cleared and must be loaded before use.
`default_nettype none

module volume_overlap_resampler #(
    parameter int SRC_NX   = vor_pkg::SRC_NX_DEF,
    parameter int SRC_NY   = vor_pkg::SRC_NY_DEF,
    parameter int SRC_NZ   = vor_pkg::SRC_NZ_DEF,
    parameter int MAX_SPAN = vor_pkg::MAX_SPAN_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire vor_pkg::in_item_t                 s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output vor_pkg::out_item_t                     m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [vor_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                       cfg_data
);

`include "volume_overlap_resampler_macros.svh"

    localparam int IW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
    localparam int CW = $clog2(MAX_SPAN + 1);
    localparam int AW = vor_pkg::ADDR_W;
    localparam int FW = vor_pkg::FRAC_W;
    localparam logic [AW-1:0] NY_K = AW'(SRC_NY);
    localparam logic [AW-1:0] NZ_K = AW'(SRC_NZ);

    // Divide step within an axis
    localparam logic [1:0] K_LO = 2'd0;
    localparam logic [1:0] K_HI = 2'd1;
    localparam logic [1:0] K_FF = 2'd2;
    localparam logic [1:0] K_FL = 2'd3;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_AX_START = 8'b0000_0010,
        ST_AX_WAIT  = 8'b0000_0100,
        ST_WINIT    = 8'b0000_1000,
        ST_WALK     = 8'b0001_0000,
        ST_DRAIN    = 8'b0010_0000,
        ST_FDIV     = 8'b0100_0000,
        ST_OUT      = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [vor_pkg::SPC_W-1:0] src_spc_reg [3];
    logic [vor_pkg::SPC_W-1:0] dst_spc_reg [3];
    logic signed [31:0]        fill_reg;

    // Per-query axis state
    logic signed [31:0] corner_reg [3];
    logic [1:0]         ax_reg;
    logic [1:0]         k_reg;
    logic signed [34:0] a_reg [3];
    logic signed [34:0] b_reg [3];
    logic [23:0]        rlo_reg [3];
    logic [23:0]        rhi_reg [3];
    logic [FW-1:0]      ffirst_reg [3];
    logic [FW-1:0]      flast_reg [3];
    logic [CW-1:0]      n_reg [3];
    logic [IW-1:0]      lastidx_reg [3];
    logic               lastok_reg [3];
    logic               single_reg [3];
    logic               clip_reg;
    logic [IW-1:0]      i_reg [3];

    // Walk pipeline
    logic                p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg;
    logic                p1_oob_reg;
    logic [FW-1:0]       p1_q_reg [3];
    logic signed [31:0]  p2_val_reg;
    logic [33:0]         p2_qxy_reg;
    logic [FW-1:0]       p2_qz_reg;
    logic signed [31:0]  p3_val_reg;
    logic [50:0]         p3_t_reg;
    logic signed [47:0]  p4_prod_reg;
    logic [14:0]         p4_w_reg;
    logic signed [63:0]  acc_reg;
    logic [33:0]         mass_reg;

    // Result holding
    logic signed [31:0]  res_pend_reg;
    logic                empty_pend_reg;
    logic                m_valid_reg;
    vor_pkg::out_item_t  m_data_reg;

    // Store and divider
    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [31:0]          ram_rdata;
    vor_pkg::div_req_t    div_req;
    vor_pkg::div_rsp_t    div_rsp;

    // Current-axis view
    logic [23:0]          s_cur;
    logic [23:0]          d_cur;
    logic signed [33:0]   lo_cur;
    logic signed [33:0]   hi_cur;
    logic [23:0]          rlo_cur;
    logic [23:0]          rhi_cur;
    logic                 neg_cur;
    logic [34:0]          q35;
    logic signed [34:0]   fl_val;
    logic [23:0]          fl_rem;

    // Walk view
    logic signed [35:0]   coord [3];
    logic                 oob;
    logic [FW-1:0]        qsel [3];
    logic [AW-1:0]        row_x;
    logic [AW-1:0]        row_xy;
    logic                 last_i [3];
    logic                 walk_end;
    logic                 pipe_empty;

    // Window setup view
    logic signed [35:0]   span [3];
    logic                 clip_ax [3];

    // Final average
    logic                 acc_neg;
    logic [63:0]          acc_mag;
    logic [63:0]          quo;
    logic [32:0]          q_sat;
    logic [32:0]          res_wide;
    logic [51:0]          t_round;
    logic [14:0]          w_cur;

    logic s_acc;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Configuration writes; unknown index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 3; j++) begin
                src_spc_reg[j] <= vor_pkg::SPC_RESET;
                dst_spc_reg[j] <= vor_pkg::SPC_RESET;
            end
            fill_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                vor_pkg::CFG_SRC_SPC_X: src_spc_reg[0] <= cfg_data[23:0];
                vor_pkg::CFG_SRC_SPC_Y: src_spc_reg[1] <= cfg_data[23:0];
                vor_pkg::CFG_SRC_SPC_Z: src_spc_reg[2] <= cfg_data[23:0];
                vor_pkg::CFG_DST_SPC_X: dst_spc_reg[0] <= cfg_data[23:0];
                vor_pkg::CFG_DST_SPC_Y: dst_spc_reg[1] <= cfg_data[23:0];
                vor_pkg::CFG_DST_SPC_Z: dst_spc_reg[2] <= cfg_data[23:0];
                vor_pkg::CFG_FILL:      fill_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Voxel store
    assign ram_we = s_acc && (s_data.kind == vor_pkg::KIND_LOAD);

    vor_ram #(
        .WIDTH (32),
        .DEPTH (vor_pkg::STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_data.load_address),
        .wdata (s_data.load_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    vor_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Current axis operands; zero spacing acts as one LSB
    always_comb begin
        s_cur   = 24'd1;
        d_cur   = 24'd1;
        lo_cur  = '0;
        rlo_cur = '0;
        rhi_cur = '0;
        for (int j = 0; j < 3; j++) begin
            if (ax_reg == 2'(j)) begin
                s_cur   = (src_spc_reg[j] == '0) ? 24'd1 : src_spc_reg[j];
                d_cur   = (dst_spc_reg[j] == '0) ? 24'd1 : dst_spc_reg[j];
                lo_cur  = 34'(corner_reg[j]);
                rlo_cur = rlo_reg[j];
                rhi_cur = rhi_reg[j];
            end
        end
        hi_cur  = lo_cur + $signed({10'b0, d_cur});
        neg_cur = (k_reg == K_LO) ? lo_cur[33] : hi_cur[33];
    end

    // Floor division fixup for negative positions
    always_comb begin
        q35 = div_rsp.quotient[34:0];
        if (!neg_cur) begin
            fl_val = $signed(q35);
            fl_rem = div_rsp.remainder[23:0];
        end else if (div_rsp.remainder == '0) begin
            fl_val = -$signed(q35);
            fl_rem = '0;
        end else begin
            fl_val = -$signed(q35) - 35'sd1;
            fl_rem = s_cur - div_rsp.remainder[23:0];
        end
    end

    // Divider request mux
    always_comb begin
        acc_neg          = acc_reg[63];
        acc_mag          = acc_neg ? (64'd0 - acc_reg) : acc_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = {10'b0, s_cur};
        if (state_reg == ST_AX_START) begin
            div_req.start = 1'b1;
            unique case (k_reg)
                K_LO: div_req.dividend = 64'(lo_cur[33] ? -lo_cur : lo_cur);
                K_HI: div_req.dividend = 64'(hi_cur[33] ? -hi_cur : hi_cur);
                K_FF: div_req.dividend = 64'({s_cur - rlo_cur, 16'b0});
                K_FL: div_req.dividend = 64'({rhi_cur, 16'b0});
                default: div_req.dividend = '0;
            endcase
        end else if (state_reg == ST_DRAIN && pipe_empty && mass_reg != '0) begin
            div_req.start    = 1'b1;
            div_req.dividend = acc_mag + 64'(mass_reg >> 1);
            div_req.divisor  = mass_reg;
        end
    end

    // Window extent per axis
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            span[j]    = {b_reg[j][34], b_reg[j]} - {a_reg[j][34], a_reg[j]} + 36'sd1;
            clip_ax[j] = span[j] > $signed(36'(MAX_SPAN));
        end
    end

    // Walk: coordinates, fractions and store address
    always_comb begin
        oob = 1'b0;
        for (int j = 0; j < 3; j++) begin
            coord[j] = {a_reg[j][34], a_reg[j]} + $signed(36'(i_reg[j]));
            if (single_reg[j]) begin
                qsel[j] = vor_pkg::FRAC_ONE;
            end else if (i_reg[j] == '0) begin
                qsel[j] = ffirst_reg[j];
            end else if (lastok_reg[j] && i_reg[j] == lastidx_reg[j]) begin
                qsel[j] = flast_reg[j];
            end else begin
                qsel[j] = vor_pkg::FRAC_ONE;
            end
            last_i[j] = (CW'(i_reg[j]) == n_reg[j] - 1'b1);
        end
        oob = coord[0][35] || coord[0] >= $signed(36'(SRC_NX)) ||
              coord[1][35] || coord[1] >= $signed(36'(SRC_NY)) ||
              coord[2][35] || coord[2] >= $signed(36'(SRC_NZ));
        row_x     = AW'(coord[0][AW-1:0] * NY_K) + coord[1][AW-1:0];
        row_xy    = AW'(row_x * NZ_K);
        ram_raddr = row_xy + coord[2][AW-1:0];
        walk_end  = last_i[0] && last_i[1] && last_i[2];
        pipe_empty = !(p1_v_reg || p2_v_reg || p3_v_reg || p4_v_reg);
        t_round   = {1'b0, p3_t_reg} + (52'd1 << 33);
        w_cur     = t_round[48:34];
    end

    // Final average: saturate, then restore sign
    always_comb begin
        quo = div_rsp.quotient;
        if (quo > 64'h8000_0000) begin
            q_sat = 33'h0_8000_0000;
        end else begin
            q_sat = quo[32:0];
        end
        if (!acc_neg && q_sat > 33'h0_7FFF_FFFF) begin
            q_sat = 33'h0_7FFF_FFFF;
        end
        res_wide = acc_neg ? (33'd0 - q_sat) : q_sat;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_data.kind == vor_pkg::KIND_QUERY) begin
                    state_next = ST_AX_START;
                end
            end
            ST_AX_START: state_next = ST_AX_WAIT;
            ST_AX_WAIT: begin
                if (div_rsp.done) begin
                    if (k_reg == K_FL && ax_reg == 2'd2) begin
                        state_next = ST_WINIT;
                    end else begin
                        state_next = ST_AX_START;
                    end
                end
            end
            ST_WINIT: state_next = ST_WALK;
            ST_WALK: begin
                if (walk_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (pipe_empty) begin
                    state_next = (mass_reg == '0) ? ST_OUT : ST_FDIV;
                end
            end
            ST_FDIV: begin
                if (div_rsp.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Axis setup and walk counters
    always_ff @(posedge aclk) begin
        if (s_acc && s_data.kind == vor_pkg::KIND_QUERY) begin
            corner_reg[0] <= s_data.corner_x;
            corner_reg[1] <= s_data.corner_y;
            corner_reg[2] <= s_data.corner_z;
            ax_reg        <= 2'd0;
            k_reg         <= K_LO;
        end
        if (state_reg == ST_AX_WAIT && div_rsp.done) begin
            for (int j = 0; j < 3; j++) begin
                if (ax_reg == 2'(j)) begin
                    unique case (k_reg)
                        K_LO: begin
                            a_reg[j]   <= fl_val;
                            rlo_reg[j] <= fl_rem;
                        end
                        K_HI: begin
                            b_reg[j]   <= fl_val;
                            rhi_reg[j] <= fl_rem;
                        end
                        K_FF: ffirst_reg[j] <= div_rsp.quotient[FW-1:0];
                        K_FL: flast_reg[j]  <= div_rsp.quotient[FW-1:0];
                        default: ;
                    endcase
                end
            end
            k_reg <= k_reg + 1'b1;
            if (k_reg == K_FL) begin
                ax_reg <= ax_reg + 1'b1;
            end
        end
        if (state_reg == ST_WINIT) begin
            clip_reg <= clip_ax[0] || clip_ax[1] || clip_ax[2];
            for (int j = 0; j < 3; j++) begin
                n_reg[j]       <= clip_ax[j] ? CW'(MAX_SPAN) : span[j][CW-1:0];
                lastidx_reg[j] <= IW'(span[j] - 36'sd1);
                lastok_reg[j]  <= !clip_ax[j];
                single_reg[j]  <= (a_reg[j] == b_reg[j]);
                i_reg[j]       <= '0;
            end
        end
        // x fastest, then y, then z
        if (state_reg == ST_WALK) begin
            if (last_i[0]) begin
                i_reg[0] <= '0;
                if (last_i[1]) begin
                    i_reg[1] <= '0;
                    i_reg[2] <= i_reg[2] + 1'b1;
                end else begin
                    i_reg[1] <= i_reg[1] + 1'b1;
                end
            end else begin
                i_reg[0] <= i_reg[0] + 1'b1;
            end
        end
    end

    // Walk pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
        end else begin
            p1_v_reg <= (state_reg == ST_WALK);
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
        end
    end

    // Walk pipeline data: read, qx*qy, *qz, round and scale, accumulate
    always_ff @(posedge aclk) begin
        p1_oob_reg <= oob;
        for (int j = 0; j < 3; j++) begin
            p1_q_reg[j] <= qsel[j];
        end
        p2_val_reg  <= p1_oob_reg ? fill_reg : $signed(ram_rdata);
        p2_qxy_reg  <= p1_q_reg[0] * p1_q_reg[1];
        p2_qz_reg   <= p1_q_reg[2];
        p3_val_reg  <= p2_val_reg;
        p3_t_reg    <= p2_qxy_reg * p2_qz_reg;
        p4_w_reg    <= w_cur;
        p4_prod_reg <= p3_val_reg * $signed({1'b0, w_cur});
        if (state_reg == ST_WINIT) begin
            acc_reg  <= '0;
            mass_reg <= '0;
        end else if (p4_v_reg) begin
            acc_reg  <= acc_reg + 64'(p4_prod_reg);
            mass_reg <= mass_reg + 34'(p4_w_reg);
        end
    end

    // Pending result
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DRAIN && pipe_empty && mass_reg == '0) begin
            res_pend_reg   <= fill_reg;
            empty_pend_reg <= 1'b1;
        end else if (state_reg == ST_FDIV && div_rsp.done) begin
            res_pend_reg   <= $signed(res_wide[31:0]);
            empty_pend_reg <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_data_reg.resampled_value <= res_pend_reg;
            m_data_reg.empty_flag      <= empty_pend_reg;
            m_data_reg.clipped_flag    <= clip_reg;
        end
    end

    // Checks
    `VOR_ASSERT_IMPLIES(a_idle_quiet, s_ready, !(p1_v_reg || p2_v_reg || p3_v_reg || p4_v_reg || div_rsp.busy))
    `VOR_ASSERT_IMPLIES(a_div_owner, div_rsp.done, (state_reg == ST_AX_WAIT) || (state_reg == ST_FDIV))
    `VOR_ASSERT_NEXT(a_out_loads, (state_reg == ST_OUT) && !m_valid_reg, m_valid_reg)

endmodule

`default_nettype wire
